// File: hdl/rmedf_pkg.sv
// Shared types, constants and codes for the rate monotonic / EDF tick scheduler.
// Used by rmedf_mod, rmedf_slots and rm_edf_tick_scheduler; depends on nothing.
`default_nettype none
package rmedf_pkg;

  localparam int TASKS  = 8;
  localparam int SLOT_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int NS_W   = SLOT_W + 1;
  localparam int ID_W   = 4;
  localparam int TICK_W = 32;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 32;
  localparam int DL_W   = 33;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [ID_W-1:0]   NONE_ID   = ID_W'(TASKS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);

  localparam logic KIND_STEP   = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_TCOUNT = 2'd1;
  localparam logic [1:0] REG_SLIMIT = 2'd2;

  localparam logic [VAL_W-1:0] SLIMIT_RESET = 16'd4096;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    TAG_IDLE = 3'd0,
    TAG_FIN  = 3'd1,
    TAG_LOST = 3'd2,
    TAG_PRE  = 3'd3,
    TAG_CUT  = 3'd4
  } tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_WAIT,
    ST_TK_SLOT,
    ST_TK_END,
    ST_FN_SLOT
  } state_t;

  typedef struct packed {
    logic [VAL_W-1:0] per;
    logic [VAL_W-1:0] bur;
    logic [VAL_W-1:0] dl;
  } param_t;

  typedef struct packed {
    logic [VAL_W-1:0] phase;
    logic [VAL_W-1:0] rem;
    logic [DL_W-1:0]  absdl;
    logic             active;
    logic [CNT_W-1:0] done;
    logic [CNT_W-1:0] lost;
    logic [CNT_W-1:0] killed;
  } job_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic              pwe;
    logic [SLOT_W-1:0] waddr;
    job_t              wdata;
    param_t            pwdata;
    logic              clear;
  } slot_req_t;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   id;
    logic              sv;
    logic [ID_W-1:0]   stask;
    logic [TICK_W-1:0] sstart;
    logic [TICK_W-1:0] send;
    tag_t              stag;
    logic              full;
    logic [CNT_W-1:0]  cc;
    logic [CNT_W-1:0]  cl;
    logic [CNT_W-1:0]  ck;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

// File: hdl/rmedf_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
// Depends on rmedf_pkg for widths.
`default_nettype none
module rmedf_mod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rmedf_pkg::TICK_W-1:0] dividend,
  input  wire logic [rmedf_pkg::VAL_W-1:0]  divisor,
  output logic                           done,
  output logic [rmedf_pkg::VAL_W-1:0]    rem
);
  import rmedf_pkg::*;

  localparam int STEP_W = $clog2(TICK_W);

  logic [TICK_W-1:0] quo_r;
  logic [VAL_W-1:0]  rem_r;
  logic [VAL_W-1:0]  div_r;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [VAL_W:0]    trial;
  logic [VAL_W:0]    diff;

  assign trial = {rem_r, quo_r[TICK_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(TICK_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[TICK_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_r <= diff[VAL_W-1:0];
      end else begin
        rem_r <= trial[VAL_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: hdl/rmedf_slots.sv
// Per-slot storage: task parameter memory and job/counter memory, both
// with registered reads. Depends on rmedf_pkg.
`default_nettype none
module rmedf_slots (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rmedf_pkg::slot_req_t  req,
  output rmedf_pkg::job_t            rjob,
  output rmedf_pkg::param_t          rpar
);
  import rmedf_pkg::*;

  param_t par_mem [TASKS];
  job_t   job_mem [TASKS];

  job_t             jrd_r;
  param_t           prd_r;
  logic [TASKS-1:0] jv_r;
  logic [TASKS-1:0] cv_r;
  logic             jvq_r;
  logic             cvq_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      job_mem[req.waddr] <= req.wdata;
    end
    if (req.pwe) begin
      par_mem[req.waddr] <= req.pwdata;
    end
    if (req.re) begin
      jrd_r <= job_mem[req.raddr];
      prd_r <= par_mem[req.raddr];
    end
  end

  // Job fields and counters each have a valid bit so that both read as zero after
  // reset, and job fields also after the end of a run, without a clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r  <= '0;
      cv_r  <= '0;
      jvq_r <= 1'b0;
      cvq_r <= 1'b0;
    end else begin
      if (req.re) begin
        jvq_r <= jv_r[req.raddr];
        cvq_r <= cv_r[req.raddr];
      end
      if (req.we) begin
        jv_r[req.waddr] <= 1'b1;
        cv_r[req.waddr] <= 1'b1;
      end
      if (req.clear) begin
        jv_r <= '0;
      end
    end
  end

  always_comb begin
    rjob = jrd_r;
    if (!jvq_r) begin
      rjob.phase  = '0;
      rjob.rem    = '0;
      rjob.absdl  = '0;
      rjob.active = 1'b0;
    end
    if (!cvq_r) begin
      rjob.done   = '0;
      rjob.lost   = '0;
      rjob.killed = '0;
    end
  end

  assign rpar = prd_r;

endmodule
`default_nettype wire

// File: hdl/rm_edf_tick_scheduler.sv
// Top level of the preemptive rate monotonic / EDF tick scheduler.
// Depends on rmedf_pkg, rmedf_mod and rmedf_slots.
`default_nettype none
// A command is accepted when start is high and busy is low; results come out
// one per cycle on out_valid and cannot be held off, so the receiver must take
// every beat as it appears. A tick issues the first slot read, then per task
// slot (8) reads, updates and writes back that slot's job record in the job
// memory, then charges the winner and closes the step; the single read port of
// that memory makes the slots go one at a time. The result appears in the cycle
// after the last of these, while the next command may already be taken. A load
// stays busy while the bit-serial remainder unit works out the slot's release
// phase (current tick modulo period), one bit per cycle. A finish emits its
// segment beat at once, then one totals beat per cycle for each slot below
// task_count (at most 8), and restarts time. Configuration writes through
// the APB port are taken at any time but must only be made while busy is low.
module rm_edf_tick_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [rmedf_pkg::SLOT_W-1:0]  in_task_index,
  input  wire logic [rmedf_pkg::VAL_W-1:0]   in_period,
  input  wire logic [rmedf_pkg::VAL_W-1:0]   in_burst,
  input  wire logic [rmedf_pkg::VAL_W-1:0]   in_deadline,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [rmedf_pkg::ID_W-1:0]         out_task_id,
  output logic                               out_seg_valid,
  output logic [rmedf_pkg::ID_W-1:0]         out_seg_task,
  output logic [rmedf_pkg::TICK_W-1:0]       out_seg_start,
  output logic [rmedf_pkg::TICK_W-1:0]       out_seg_end,
  output logic [2:0]                         out_seg_tag,
  output logic                               out_trace_full,
  output logic [rmedf_pkg::CNT_W-1:0]        out_count_complete,
  output logic [rmedf_pkg::CNT_W-1:0]        out_count_lost,
  output logic [rmedf_pkg::CNT_W-1:0]        out_count_killed,
  output logic                               out_last,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rmedf_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rmedf_pkg::DATA_W-1:0]  pwdata,
  output logic [rmedf_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);
  import rmedf_pkg::*;

  // Configuration registers.
  logic             policy_r;
  logic [3:0]       tcount_r;
  logic [VAL_W-1:0] slimit_r;
  logic             cfg_wr;

  // Scheduler state.
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [ID_W-1:0]   owner_r, owner_nxt;
  logic [TICK_W-1:0] since_r, since_nxt;
  logic [VAL_W-1:0]  segcnt_r, segcnt_nxt;
  logic [ID_W-1:0]   best_r, best_nxt;
  logic [DL_W-1:0]   bkey_r, bkey_nxt;
  job_t              brec_r, brec_nxt;
  logic              segc_v_r, segc_v_nxt;
  logic [ID_W-1:0]   segc_task_r, segc_task_nxt;
  logic [TICK_W-1:0] segc_start_r, segc_start_nxt;
  tag_t              segc_tag_r, segc_tag_nxt;
  logic              ov_r, ov_nxt;
  res_t              res_r, res_nxt;

  // Datapath helpers.
  slot_req_t         req;
  job_t              rjob;
  param_t            rpar;
  job_t              jn;
  logic              accept;
  op_t               op;
  logic [NS_W-1:0]   n_eff;
  logic              in_n;
  logic              is_own;
  logic              rel;
  logic [VAL_W-1:0]  ph;
  logic [DL_W-1:0]   key;
  logic              fn_last;
  logic              s_ok;
  logic [ID_W-1:0]   s_task;
  logic [TICK_W-1:0] s_start;
  tag_t              s_tag;
  logic              mod_done;
  logic [VAL_W-1:0]  mod_rem;

  assign accept  = start && (state_r == ST_IDLE);
  assign op      = op_t'(in_operation);
  assign busy    = (state_r != ST_IDLE);
  assign n_eff   = (int'(tcount_r) > TASKS) ? NS_W'(TASKS) : NS_W'(tcount_r);
  assign in_n    = ({1'b0, slot_r} < n_eff);
  assign is_own  = (owner_r == ID_W'(slot_r));
  assign fn_last = (({1'b0, slot_r} + NS_W'(1)) == n_eff);

  // APB register file; the port never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
      tcount_r <= '0;
      slimit_r <= SLIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_POLICY: policy_r <= pwdata[0];
        REG_TCOUNT: tcount_r <= pwdata[3:0];
        REG_SLIMIT: slimit_r <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = DATA_W'(policy_r);
      REG_TCOUNT: prdata = DATA_W'(tcount_r);
      REG_SLIMIT: prdata = DATA_W'(slimit_r);
      default:    prdata = '0;
    endcase
  end

  rmedf_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && (op == OP_LOAD)),
    .dividend (tick_r),
    .divisor  (in_period),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  rmedf_slots u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rjob  (rjob),
    .rpar  (rpar)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_LOAD:   state_nxt = ST_LD_WAIT;
            OP_TICK:   state_nxt = ST_TK_SLOT;
            OP_FINISH: state_nxt = (n_eff != '0) ? ST_FN_SLOT : ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_WAIT: if (mod_done) state_nxt = ST_IDLE;
      ST_TK_SLOT: if (slot_r == LAST_SLOT) state_nxt = ST_TK_END;
      ST_TK_END:  state_nxt = ST_IDLE;
      ST_FN_SLOT: if (fn_last) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Per-slot tick update of the job record that was read last cycle. The
  // finishing owner, an expiring job, a release and the priority race for this
  // slot are all settled here in the order the schedule defines.
  always_comb begin
    jn     = rjob;
    ph     = (tick_r == '0) ? '0 : rjob.phase;
    rel    = in_n && (rpar.per != '0) && (ph == '0);
    if (rpar.per != '0) begin
      jn.phase = ((ph + 16'd1) == rpar.per) ? '0 : ph + 16'd1;
    end
    if (is_own && (rjob.rem == '0)) begin
      jn.done   = rjob.done + 1'b1;
      jn.active = 1'b0;
    end else if (in_n && rjob.active && (rjob.rem != '0)
                 && (rjob.absdl == {1'b0, tick_r})) begin
      jn.lost   = rjob.lost + 1'b1;
      jn.active = 1'b0;
    end
    if (rel) begin
      jn.rem    = rpar.bur;
      jn.absdl  = {1'b0, tick_r} + DL_W'(rpar.dl);
      jn.active = 1'b1;
    end
    key = policy_r ? jn.absdl : DL_W'(rpar.per);
  end

  // Datapath and result outputs.
  always_comb begin
    slot_nxt       = slot_r;
    tick_nxt       = tick_r;
    owner_nxt      = owner_r;
    since_nxt      = since_r;
    segcnt_nxt     = segcnt_r;
    best_nxt       = best_r;
    bkey_nxt       = bkey_r;
    brec_nxt       = brec_r;
    segc_v_nxt     = segc_v_r;
    segc_task_nxt  = segc_task_r;
    segc_start_nxt = segc_start_r;
    segc_tag_nxt   = segc_tag_r;
    ov_nxt         = 1'b0;
    res_nxt        = res_r;
    req            = '0;
    s_ok           = 1'b0;
    s_task         = owner_r;
    s_start        = since_r;
    s_tag          = TAG_IDLE;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD: begin
              req.pwe    = 1'b1;
              req.waddr  = in_task_index;
              req.pwdata = '{per: in_period, bur: in_burst, dl: in_deadline};
              req.re     = 1'b1;
              req.raddr  = in_task_index;
              slot_nxt   = in_task_index;
            end
            OP_TICK: begin
              req.re     = 1'b1;
              req.raddr  = '0;
              slot_nxt   = '0;
              best_nxt   = NONE_ID;
              bkey_nxt   = '0;
              segc_v_nxt = 1'b0;
            end
            OP_FINISH: begin
              // Cut the running segment at the current tick.
              s_tag      = (owner_r != NONE_ID) ? TAG_CUT : TAG_IDLE;
              s_ok       = (tick_r > since_r) && (segcnt_r < slimit_r);
              segcnt_nxt = s_ok ? segcnt_r + 1'b1 : segcnt_r;
              ov_nxt     = 1'b1;
              res_nxt    = '0;
              res_nxt.kind   = KIND_STEP;
              res_nxt.id     = NONE_ID;
              res_nxt.sv     = s_ok;
              res_nxt.stask  = s_ok ? owner_r : NONE_ID;
              res_nxt.sstart = s_ok ? since_r : '0;
              res_nxt.send   = s_ok ? tick_r : '0;
              res_nxt.stag   = s_ok ? s_tag : TAG_IDLE;
              res_nxt.full   = (segcnt_nxt >= slimit_r);
              res_nxt.last   = (n_eff == '0);
              if (n_eff == '0) begin
                req.clear  = 1'b1;
                tick_nxt   = '0;
                owner_nxt  = NONE_ID;
                since_nxt  = '0;
                segcnt_nxt = '0;
              end else begin
                req.re    = 1'b1;
                req.raddr = '0;
                slot_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      ST_LD_WAIT: begin
        if (mod_done) begin
          req.we           = 1'b1;
          req.waddr        = slot_r;
          req.wdata        = rjob;
          req.wdata.phase  = mod_rem;
          req.wdata.done   = '0;
          req.wdata.lost   = '0;
          req.wdata.killed = '0;
        end
      end

      ST_TK_SLOT: begin
        req.we    = 1'b1;
        req.waddr = slot_r;
        req.wdata = jn;
        if (slot_r != LAST_SLOT) begin
          req.re    = 1'b1;
          req.raddr = slot_r + 1'b1;
          slot_nxt  = slot_r + 1'b1;
        end
        // Owner leaves by finishing or by missing its deadline.
        if (is_own && (rjob.rem == '0)) begin
          segc_v_nxt     = 1'b1;
          segc_task_nxt  = owner_r;
          segc_start_nxt = since_r;
          segc_tag_nxt   = TAG_FIN;
          owner_nxt      = NONE_ID;
          since_nxt      = tick_r;
        end else if (is_own && in_n && rjob.active && (rjob.rem != '0)
                     && (rjob.absdl == {1'b0, tick_r})) begin
          segc_v_nxt     = 1'b1;
          segc_task_nxt  = owner_r;
          segc_start_nxt = since_r;
          segc_tag_nxt   = TAG_LOST;
          owner_nxt      = NONE_ID;
          since_nxt      = tick_r;
        end
        if (in_n && jn.active && (jn.rem != '0)
            && ((best_r == NONE_ID) || (key < bkey_r))) begin
          best_nxt = ID_W'(slot_r);
          bkey_nxt = key;
          brec_nxt = jn;
        end
      end

      ST_TK_END: begin
        // At most one segment can be non-empty per tick: an owner that left
        // during the pass already moved since_r to this tick.
        if (segc_v_r) begin
          s_task  = segc_task_r;
          s_start = segc_start_r;
          s_tag   = segc_tag_r;
        end else begin
          s_tag = (owner_r != NONE_ID) ? TAG_PRE : TAG_IDLE;
        end
        s_ok = (segc_v_r || (owner_r != best_r)) && (tick_r > s_start)
               && (segcnt_r < slimit_r);
        segcnt_nxt = s_ok ? segcnt_r + 1'b1 : segcnt_r;
        if (owner_r != best_r) begin
          owner_nxt = best_r;
          since_nxt = tick_r;
        end
        if (best_r != NONE_ID) begin
          req.we        = 1'b1;
          req.waddr     = best_r[SLOT_W-1:0];
          req.wdata     = brec_r;
          req.wdata.rem = brec_r.rem - 1'b1;
        end
        tick_nxt       = tick_r + 1'b1;
        ov_nxt         = 1'b1;
        res_nxt        = '0;
        res_nxt.kind   = KIND_STEP;
        res_nxt.id     = best_r;
        res_nxt.sv     = s_ok;
        res_nxt.stask  = s_ok ? s_task : NONE_ID;
        res_nxt.sstart = s_ok ? s_start : '0;
        res_nxt.send   = s_ok ? tick_r : '0;
        res_nxt.stag   = s_ok ? s_tag : TAG_IDLE;
        res_nxt.full   = (segcnt_nxt >= slimit_r);
        res_nxt.last   = 1'b1;
      end

      ST_FN_SLOT: begin
        req.we    = 1'b1;
        req.waddr = slot_r;
        req.wdata = rjob;
        if (rjob.active && (rjob.rem != '0)) begin
          req.wdata.killed = rjob.killed + 1'b1;
        end
        ov_nxt        = 1'b1;
        res_nxt       = '0;
        res_nxt.kind  = KIND_TOTALS;
        res_nxt.id    = ID_W'(slot_r);
        res_nxt.stask = NONE_ID;
        res_nxt.stag  = TAG_IDLE;
        res_nxt.full  = (segcnt_r >= slimit_r);
        res_nxt.cc    = rjob.done;
        res_nxt.cl    = rjob.lost;
        res_nxt.ck    = req.wdata.killed;
        res_nxt.last  = fn_last;
        if (fn_last) begin
          // Restart time; the clear wins over this cycle's write-back.
          req.clear  = 1'b1;
          tick_nxt   = '0;
          owner_nxt  = NONE_ID;
          since_nxt  = '0;
          segcnt_nxt = '0;
        end else begin
          req.re    = 1'b1;
          req.raddr = slot_r + 1'b1;
          slot_nxt  = slot_r + 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      slot_r   <= '0;
      tick_r   <= '0;
      owner_r  <= NONE_ID;
      since_r  <= '0;
      segcnt_r <= '0;
      best_r   <= NONE_ID;
      segc_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slot_r   <= slot_nxt;
      tick_r   <= tick_nxt;
      owner_r  <= owner_nxt;
      since_r  <= since_nxt;
      segcnt_r <= segcnt_nxt;
      best_r   <= best_nxt;
      segc_v_r <= segc_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bkey_r       <= bkey_nxt;
    brec_r       <= brec_nxt;
    segc_task_r  <= segc_task_nxt;
    segc_start_r <= segc_start_nxt;
    segc_tag_r   <= segc_tag_nxt;
    if (ov_nxt) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = res_r.kind;
  assign out_task_id        = res_r.id;
  assign out_seg_valid      = res_r.sv;
  assign out_seg_task       = res_r.stask;
  assign out_seg_start      = res_r.sstart;
  assign out_seg_end        = res_r.send;
  assign out_seg_tag        = res_r.stag;
  assign out_trace_full     = res_r.full;
  assign out_count_complete = res_r.cc;
  assign out_count_lost     = res_r.cl;
  assign out_count_killed   = res_r.ck;
  assign out_last           = res_r.last;

  a_owner_range: assert property (@(posedge clk) disable iff (!rst_n)
    owner_r <= NONE_ID)
    else $error("owner register holds a slot beyond the task range");

  a_totals_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TOTALS) |-> !out_seg_valid)
    else $error("totals beat carries a segment");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TK_END) |=> out_valid && out_last && (out_kind == KIND_STEP))
    else $error("tick did not end in a single step beat");

endmodule
`default_nettype wire

// File: test/rm_edf_tick_scheduler_tb.sv
// Testbench for rm_edf_tick_scheduler: directed and random command beats against a
// cycle-free scheduler predictor, results checked in order. Depends on rmedf_pkg and the RTL.
`default_nettype none
module rm_edf_tick_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmedf_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  // A load keeps the block busy behind its remainder pass and gives no result,
  // so leave a margin past that before touching registers.
  localparam int SETTLE_CYCLES  = 48;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_operation = 2'd0;
  logic [SLOT_W-1:0] in_task_index = '0;
  logic [VAL_W-1:0] in_period = '0, in_burst = '0, in_deadline = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire busy, out_valid, out_kind, out_seg_valid, out_trace_full, out_last, pready;
  wire [ID_W-1:0] out_task_id, out_seg_task;
  wire [TICK_W-1:0] out_seg_start, out_seg_end;
  wire [2:0] out_seg_tag;
  wire [CNT_W-1:0] out_count_complete, out_count_lost, out_count_killed;
  wire [DATA_W-1:0] prdata;

  rm_edf_tick_scheduler DUT (.*);

  always #2 clk = ~clk;

  // Scheduler state as the predictor sees it.
  logic              sch_policy;
  logic [3:0]        sch_tcount;
  logic [15:0]       sch_slimit;
  logic [31:0]       sch_tick, sch_since;
  logic [3:0]        sch_owner;
  logic [15:0]       sch_segs;
  logic [15:0]       sch_per [TASKS], sch_bur [TASKS], sch_dl [TASKS], sch_rem [TASKS];
  logic [32:0]       sch_absdl [TASKS];
  logic              sch_active [TASKS];
  logic [31:0]       sch_done [TASKS], sch_lost [TASKS], sch_killed [TASKS];
  // The segment closed by the current item, if any.
  logic              seg_ok;
  logic [3:0]        seg_owner;
  logic [31:0]       seg_from, seg_to;
  tag_t              seg_kind;

  res_t expected_beats [$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   quiet_cycles = 0;

  task automatic restart_jobs();
    for (int i = 0; i < TASKS; i++) begin
      sch_rem[i] = '0;
      sch_absdl[i] = '0;
      sch_active[i] = 1'b0;
    end
    sch_owner = NONE_ID;
    sch_since = '0;
    sch_segs = '0;
    sch_tick = '0;
  endtask

  task automatic close_segment(logic [3:0] owner, logic [31:0] from, logic [31:0] to,
                               tag_t kind);
    if (to <= from || sch_segs >= sch_slimit) return;
    sch_segs = sch_segs + 16'd1;
    seg_ok = 1'b1;
    seg_owner = owner;
    seg_from = from;
    seg_to = to;
    seg_kind = kind;
  endtask

  function automatic res_t make_beat(logic kind, logic [3:0] id, logic [31:0] c,
                                     logic [31:0] l, logic [31:0] k, logic lst);
    res_t r;
    r.kind = kind;
    r.id = id;
    r.sv = seg_ok;
    r.stask = seg_ok ? seg_owner : NONE_ID;
    r.sstart = seg_ok ? seg_from : '0;
    r.send = seg_ok ? seg_to : '0;
    r.stag = seg_ok ? seg_kind : TAG_IDLE;
    r.full = (sch_segs >= sch_slimit);
    r.cc = c;
    r.cl = l;
    r.ck = k;
    r.last = lst;
    return r;
  endfunction

  // One scheduler tick in the order the block runs it.
  task automatic advance_tick();
    logic [31:0] t;
    int n;
    logic [3:0] best;
    logic [32:0] bkey, key;
    t = sch_tick;
    n = (sch_tcount > TASKS) ? TASKS : sch_tcount;
    best = NONE_ID;
    bkey = '0;
    if (sch_owner < TASKS && sch_rem[sch_owner] == 0) begin
      close_segment(sch_owner, sch_since, t, TAG_FIN);
      sch_done[sch_owner] += 1;
      sch_active[sch_owner] = 1'b0;
      sch_owner = NONE_ID;
      sch_since = t;
    end
    for (int i = 0; i < n; i++) begin
      if (sch_active[i] && sch_rem[i] != 0 && sch_absdl[i] == {1'b0, t}) begin
        if (sch_owner == i) begin
          close_segment(sch_owner, sch_since, t, TAG_LOST);
          sch_owner = NONE_ID;
          sch_since = t;
        end
        sch_lost[i] += 1;
        sch_active[i] = 1'b0;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (sch_per[i] != 0 && (t % sch_per[i]) == 0) begin
        sch_rem[i] = sch_bur[i];
        sch_absdl[i] = {1'b0, t} + sch_dl[i];
        sch_active[i] = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (sch_active[i] && sch_rem[i] != 0) begin
        key = sch_policy ? sch_absdl[i] : 33'(sch_per[i]);
        if (best == NONE_ID || key < bkey) begin
          best = 4'(i);
          bkey = key;
        end
      end
    end
    if (best != sch_owner) begin
      close_segment(sch_owner, sch_since, t, (sch_owner != NONE_ID) ? TAG_PRE : TAG_IDLE);
      sch_owner = best;
      sch_since = t;
    end
    if (best != NONE_ID) sch_rem[best] -= 1;
    sch_tick = t + 1;
  endtask

  // Works out the result beats of one accepted command.
  task automatic schedule_command(op_t op, logic [2:0] idx, logic [15:0] per,
                                  logic [15:0] bur, logic [15:0] dl);
    int n;
    seg_ok = 1'b0;
    case (op)
      OP_LOAD: begin
        sch_per[idx] = per;
        sch_bur[idx] = bur;
        sch_dl[idx] = dl;
        sch_done[idx] = '0;
        sch_lost[idx] = '0;
        sch_killed[idx] = '0;
      end
      OP_TICK: begin
        advance_tick();
        expected_beats.push_back(make_beat(KIND_STEP, sch_owner, 0, 0, 0, 1'b1));
      end
      OP_FINISH: begin
        n = (sch_tcount > TASKS) ? TASKS : sch_tcount;
        close_segment(sch_owner, sch_since, sch_tick,
                      (sch_owner != NONE_ID) ? TAG_CUT : TAG_IDLE);
        for (int i = 0; i < n; i++)
          if (sch_active[i] && sch_rem[i] > 0) sch_killed[i] += 1;
        expected_beats.push_back(make_beat(KIND_STEP, NONE_ID, 0, 0, 0, n == 0));
        seg_ok = 1'b0;
        for (int i = 0; i < n; i++)
          expected_beats.push_back(make_beat(KIND_TOTALS, 4'(i), sch_done[i], sch_lost[i],
                                             sch_killed[i], i + 1 == n));
        restart_jobs();
      end
      default: ;
    endcase
  endtask

  // Drives one command beat and waits for the block to take it. start is only
  // lowered when the sender idles first, so back-to-back beats keep it high.
  task automatic send_command(op_t op, logic [2:0] idx = 0, logic [15:0] per = 1,
                              logic [15:0] bur = 0, logic [15:0] dl = 0);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_operation <= op;
    in_task_index <= idx;
    in_period <= per;
    in_burst <= bur;
    in_deadline <= dl;
    do @(posedge clk); while (busy);
    schedule_command(op, idx, per, bur, dl);
  endtask

  // Waits until every expected beat has come and the block has gone quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write; the bus goes idle before the task returns.
  task automatic write_register(logic [1:0] reg_index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (reg_index)
      REG_POLICY: sch_policy = value[0];
      REG_TCOUNT: sch_tcount = value[3:0];
      REG_SLIMIT: sch_slimit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic pol, logic [3:0] cnt, logic [15:0] lim);
    drain();
    write_register(REG_POLICY, {31'd0, pol});
    write_register(REG_TCOUNT, {28'd0, cnt});
    write_register(REG_SLIMIT, {16'd0, lim});
  endtask

  // Extremes of every field, each special case, then a finish.
  task automatic test_directed();
    // Deadline lost, preemption, zero burst, zero deadline and the widest values.
    send_command(OP_LOAD, 0, 10, 5, 10);
    send_command(OP_LOAD, 1, 3, 1, 3);
    send_command(OP_LOAD, 2, 4, 3, 2);
    send_command(OP_LOAD, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(OP_LOAD, 4, 5, 0, 5);
    send_command(OP_LOAD, 5, 6, 2, 0);
    send_command(OP_LOAD, 6, 2, 1, 2);
    send_command(OP_LOAD, 7, 7, 2, 7);
    configure(1'b0, 4'd8, 16'd4096);
    repeat (10) send_command(OP_TICK);
    send_command(OP_NOP, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_command(OP_FINISH);
  endtask

  // Earliest deadline order with a nearly full trace and few slots.
  task automatic test_edf_trace_limit();
    configure(1'b1, 4'd5, 16'd2);
    repeat (8) send_command(OP_TICK);
    send_command(OP_FINISH);
    configure(1'b1, 4'd0, 16'd0);
    repeat (3) send_command(OP_TICK);
    send_command(OP_FINISH);
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 6));
      3: return 16'hFFFF;
      4: return 16'($urandom_range(65535));
      default: return 16'd4096;
    endcase
  endfunction

  // Mostly well-formed runs: a setting, a few reloads, a run of ticks with some
  // noise, and a finish.
  task automatic test_random_runs(int runs);
    logic [3:0] cnt;
    for (int r = 0; r < runs; r++) begin
      case ($urandom_range(3))
        0: cnt = 4'd0;
        1: cnt = 4'd8;
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      configure(1'($urandom_range(1)), cnt, pick_limit());
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) == 0)
          send_command(OP_LOAD, 3'($urandom_range(7)), 16'($urandom_range(1, 65535)),
                       16'($urandom_range(65535)), 16'($urandom_range(65535)));
        else
          send_command(OP_LOAD, 3'($urandom_range(7)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(0, 5)), 16'($urandom_range(0, 14)));
      end
      repeat ($urandom_range(12, 30)) begin
        case ($urandom_range(19))
          0: send_command(OP_NOP, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                          16'($urandom));
          1: send_command(OP_LOAD, 3'($urandom_range(7)), 16'($urandom_range(1, 9)),
                          16'($urandom_range(0, 4)), 16'($urandom_range(0, 10)));
          2: send_command(OP_FINISH);
          default: send_command(OP_TICK);
        endcase
      end
      send_command(OP_FINISH);
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid) begin
      got.kind = out_kind;
      got.id = out_task_id;
      got.sv = out_seg_valid;
      got.stask = out_seg_task;
      got.sstart = out_seg_start;
      got.send = out_seg_end;
      got.stag = tag_t'(out_seg_tag);
      got.full = out_trace_full;
      got.cc = out_count_complete;
      got.cl = out_count_lost;
      got.ck = out_count_killed;
      got.last = out_last;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    sch_policy = 1'b0;
    sch_tcount = '0;
    sch_slimit = SLIMIT_RESET;
    for (int i = 0; i < TASKS; i++) begin
      sch_per[i] = '0;
      sch_bur[i] = '0;
      sch_dl[i] = '0;
      sch_done[i] = '0;
      sch_lost[i] = '0;
      sch_killed[i] = '0;
    end
    restart_jobs();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The sender idles at times in the first part, more often later, then not at all.
    idle_pct = 36;
    test_directed();
    test_edf_trace_limit();
    test_random_runs(4);
    idle_pct = 77;
    test_random_runs(4);
    idle_pct = 0;
    test_random_runs(5);
    drain();
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
